// File: design/mtg_pkg.sv
// ============================================================================
// mtg_pkg
// Shared constants, types and word functions of the 64-bit Mersenne Twister.
// ============================================================================
`default_nettype none

package mtg_pkg;

  localparam int STATE_WORDS  = 312;
  localparam int SHIFT_OFFSET = 156;
  localparam int IDX_W        = 9;
  localparam int WORD_W       = 64;
  localparam int HALF_W       = 32;

  localparam logic [WORD_W-1:0] TWIST_MATRIX = 64'hB502_6F5A_A966_19E9;
  localparam logic [WORD_W-1:0] UPPER_MASK   = 64'hFFFF_FFFF_8000_0000;
  localparam logic [WORD_W-1:0] LOWER_MASK   = 64'h0000_0000_7FFF_FFFF;
  localparam logic [WORD_W-1:0] TEMPER_A     = 64'h5555_5555_5555_5555;
  localparam logic [WORD_W-1:0] TEMPER_B     = 64'h71D6_7FFF_EDA6_0000;
  localparam logic [WORD_W-1:0] TEMPER_C     = 64'hFFF7_EEE0_0000_0000;

  localparam logic [IDX_W-1:0] IDX_END  = IDX_W'(STATE_WORDS);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(STATE_WORDS - 1);
  localparam logic [IDX_W-1:0] IDX_OFFS = IDX_W'(SHIFT_OFFSET);

  typedef enum logic [1:0] {
    OP_DRAW64 = 2'd0,
    OP_DRAW32 = 2'd1,
    OP_LOAD   = 2'd2
  } op_t;

  // controller to datapath
  typedef struct packed {
    logic load_wr;    // write one state word from the request
    logic rd_draw;    // read the word at the read index
    logic rd_prime;   // start a twist pass: read word 0
    logic tw_issue;   // issue the reads of one twist step
    logic out_draw;   // temper the read word into the output register
    logic draw_half;  // with out_draw: low half out, high half saved
    logic out_saved;  // saved high half into the output register
  } mtg_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic idx_end;
    logic half_pending;
    logic slot_free;
    logic twist_last;
  } mtg_stat_t;

  function automatic logic [WORD_W-1:0] mix_word(input logic [WORD_W-1:0] hi_src,
                                                 input logic [WORD_W-1:0] lo_src,
                                                 input logic [WORD_W-1:0] far);
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] r;
    y = (hi_src & UPPER_MASK) | (lo_src & LOWER_MASK);
    r = far ^ (y >> 1);
    if (y[0]) begin
      r = r ^ TWIST_MATRIX;
    end
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] x;
    x = w;
    x = x ^ ((x >> 29) & TEMPER_A);
    x = x ^ ((x << 17) & TEMPER_B);
    x = x ^ ((x << 37) & TEMPER_C);
    x = x ^ (x >> 43);
    return x;
  endfunction

endpackage

`default_nettype wire

// File: design/mtg_if.sv
// ============================================================================
// mtg_if
// Valid/ready channels: request side and result side.
// ============================================================================
`default_nettype none

interface mtg_in_if import mtg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [IDX_W-1:0]  load_index;
  logic [WORD_W-1:0] load_value;

  modport source (output valid, output op, output load_index, output load_value,
                  input ready);
  modport sink   (input valid, input op, input load_index, input load_value,
                  output ready);
endinterface

interface mtg_out_if import mtg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] random_value;

  modport source (output valid, output random_value, input ready);
  modport sink   (input valid, input random_value, output ready);
endinterface

`default_nettype wire

// File: design/mtg_ram.sv
// ============================================================================
// mtg_ram
// Generic RAM: one write port, two read ports, registered read data.
// ============================================================================
`default_nettype none

module mtg_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 312
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic      [WIDTH-1:0]         rdata_a,
  input  wire logic                     re_b,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

// File: design/mtg_datapath.sv
// ============================================================================
// mtg_datapath
// State memory, twist pipeline, read index, tempering and output register.
// ============================================================================
`default_nettype none

module mtg_datapath import mtg_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mtg_cmd_t          cmd,
  output mtg_stat_t              stat,
  input  wire logic [IDX_W-1:0]  load_index,
  input  wire logic [WORD_W-1:0] load_value,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [WORD_W-1:0]      out_value
);

  logic [IDX_W-1:0]  read_index_r, read_index_nxt;
  logic [IDX_W-1:0]  twist_k_r, twist_k_nxt;
  logic [IDX_W-1:0]  wr_k_r;
  logic              wr_v_r;
  logic              hi_v_r;
  logic [WORD_W-1:0] hi_r;
  logic              half_pending_r, half_pending_nxt;
  logic [HALF_W-1:0] saved_high_r, saved_high_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_value_r, out_value_nxt;

  logic              load_ok;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re_a, ram_re_b;
  logic [IDX_W-1:0]  ram_raddr_a, ram_raddr_b;
  logic [WORD_W-1:0] ram_rdata_a, ram_rdata_b;
  logic [IDX_W-1:0]  nxt_k, far_k;
  logic [WORD_W-1:0] tempered;

  assign load_ok = cmd.load_wr && (load_index < IDX_END);

  // neighbour and far word of the current twist step
  assign nxt_k = (twist_k_r == IDX_LAST) ? '0 : twist_k_r + 1'b1;
  assign far_k = (twist_k_r < IDX_OFFS) ? twist_k_r + IDX_OFFS : twist_k_r - IDX_OFFS;

  always_comb begin
    ram_we      = load_ok || wr_v_r;
    ram_waddr   = load_ok ? load_index : wr_k_r;
    ram_wdata   = load_ok ? load_value : mix_word(hi_r, ram_rdata_a, ram_rdata_b);
    ram_re_a    = cmd.rd_draw || cmd.rd_prime || cmd.tw_issue;
    ram_raddr_a = cmd.rd_draw ? read_index_r : (cmd.rd_prime ? '0 : nxt_k);
    ram_re_b    = cmd.tw_issue;
    ram_raddr_b = far_k;
  end

  mtg_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STATE_WORDS)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re_a    (ram_re_a),
    .raddr_a (ram_raddr_a),
    .rdata_a (ram_rdata_a),
    .re_b    (ram_re_b),
    .raddr_b (ram_raddr_b),
    .rdata_b (ram_rdata_b)
  );

  assign tempered = temper(ram_rdata_a);

  always_comb begin
    read_index_nxt = read_index_r;
    if (load_ok) begin
      read_index_nxt = IDX_END;
    end else if (cmd.rd_prime) begin
      read_index_nxt = '0;
    end else if (cmd.rd_draw) begin
      read_index_nxt = read_index_r + 1'b1;
    end

    twist_k_nxt = twist_k_r;
    if (cmd.rd_prime) begin
      twist_k_nxt = '0;
    end else if (cmd.tw_issue) begin
      twist_k_nxt = twist_k_r + 1'b1;
    end

    half_pending_nxt = half_pending_r;
    saved_high_nxt   = saved_high_r;
    out_value_nxt    = out_value_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    if (cmd.out_draw) begin
      out_valid_nxt = 1'b1;
      if (cmd.draw_half) begin
        out_value_nxt    = {{HALF_W{1'b0}}, tempered[HALF_W-1:0]};
        saved_high_nxt   = tempered[WORD_W-1:HALF_W];
        half_pending_nxt = 1'b1;
      end else begin
        out_value_nxt = tempered;
      end
    end else if (cmd.out_saved) begin
      out_valid_nxt    = 1'b1;
      out_value_nxt    = {{HALF_W{1'b0}}, saved_high_r};
      half_pending_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_index_r   <= IDX_END;
      wr_v_r         <= 1'b0;
      hi_v_r         <= 1'b0;
      half_pending_r <= 1'b0;
      saved_high_r   <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      read_index_r   <= read_index_nxt;
      wr_v_r         <= cmd.tw_issue;
      hi_v_r         <= cmd.rd_prime || cmd.tw_issue;
      half_pending_r <= half_pending_nxt;
      saved_high_r   <= saved_high_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    twist_k_r   <= twist_k_nxt;
    wr_k_r      <= twist_k_r;
    out_value_r <= out_value_nxt;
    if (hi_v_r) begin
      hi_r <= ram_rdata_a;   // old word k, read as the neighbour of step k-1
    end
  end

  assign stat.idx_end      = (read_index_r == IDX_END);
  assign stat.half_pending = half_pending_r;
  assign stat.slot_free    = !out_valid_r || out_ready;
  assign stat.twist_last   = (twist_k_r == IDX_LAST);

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

`ifndef NO_ASSERTIONS
  a_no_load_in_twist: assert property (@(posedge clk) disable iff (!rst_n)
    wr_v_r |-> !cmd.load_wr)
    else $error("load during twist write-back");
  a_draw_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_draw |-> (read_index_r < IDX_END))
    else $error("draw read beyond state");
  a_saved_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_saved |-> half_pending_r)
    else $error("saved half sent without one pending");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(out_value_r))
    else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

// File: design/mtg_ctrl.sv
// ============================================================================
// mtg_ctrl
// Request sequencer: loads, draws, twist passes and output hand-off.
// ============================================================================
`default_nettype none

module mtg_ctrl import mtg_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_op,
  input  wire mtg_stat_t  stat,
  output mtg_cmd_t        cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TW_PRIME,
    S_TW_RUN,
    S_TW_DRAIN,
    S_DRAW_CAP,
    S_HALF_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   is_half_r, is_half_nxt;
  op_t    op;
  logic   accept;

  assign op       = op_t'(in_op);
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt   = state_r;
    is_half_nxt = is_half_r;
    cmd         = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_LOAD: begin
              cmd.load_wr = 1'b1;
            end
            OP_DRAW64, OP_DRAW32: begin
              if (op == OP_DRAW32 && stat.half_pending) begin
                state_nxt = S_HALF_OUT;
              end else begin
                is_half_nxt = (op == OP_DRAW32);
                if (stat.idx_end) begin
                  state_nxt = S_TW_PRIME;
                end else begin
                  cmd.rd_draw = 1'b1;
                  state_nxt   = S_DRAW_CAP;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_TW_PRIME: begin
        cmd.rd_prime = 1'b1;
        state_nxt    = S_TW_RUN;
      end
      S_TW_RUN: begin
        cmd.tw_issue = 1'b1;
        if (stat.twist_last) begin
          state_nxt = S_TW_DRAIN;
        end
      end
      S_TW_DRAIN: begin
        // last twist write lands now; word 0 is long settled
        cmd.rd_draw = 1'b1;
        state_nxt   = S_DRAW_CAP;
      end
      S_DRAW_CAP: begin
        if (stat.slot_free) begin
          cmd.out_draw  = 1'b1;
          cmd.draw_half = is_half_r;
          state_nxt     = S_IDLE;
        end
      end
      S_HALF_OUT: begin
        if (stat.slot_free) begin
          cmd.out_saved = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      is_half_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      is_half_r <= is_half_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_out_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_draw || cmd.out_saved) |-> stat.slot_free)
    else $error("result written into a full output register");
  a_twist_ends_in_draw: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TW_DRAIN) |=> (state_r == S_DRAW_CAP))
    else $error("twist pass not followed by its draw");
  a_prime_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_prime |=> cmd.tw_issue)
    else $error("twist steps did not follow the priming read");
`endif

endmodule

`default_nettype wire

// File: design/mersenne_twister_64_generator_core.sv
// ============================================================================
// mersenne_twister_64_generator_core
// 64-bit Mersenne Twister: loads state words, gives tempered draws.
// ============================================================================
// Draws: a draw's state read is issued when its request is taken (or after a
//   twist pass: prime read, 312 pipelined twist steps over the two-read-port
//   state RAM, drain, read); its tempered result is registered once the output
//   register is free. A new request is taken only when the last is done; one
//   twist pass runs per 312 words; a load is written in the cycle it is taken.
// Reset: read index at the end of state (first draw twists), no half saved,
//   output empty; state RAM is not cleared and must be loaded before drawing.
`default_nettype none

module mersenne_twister_64_generator_core import mtg_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  mtg_in_if.sink    in_chan,
  mtg_out_if.source out_chan
);

  mtg_cmd_t  cmd;
  mtg_stat_t stat;

  // sequencer: takes one request at a time, drives the datapath by command
  mtg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .in_op    (in_chan.op),
    .stat     (stat),
    .cmd      (cmd)
  );

  // state RAM, twist pipeline, tempering and the output register
  mtg_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .load_index (in_chan.load_index),
    .load_value (in_chan.load_value),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .out_value  (out_chan.random_value)
  );

endmodule

`default_nettype wire
